// File: rtl/aabb_pct_pkg.sv
`timescale 1ns / 1ps

package aabb_pct_pkg;

   localparam int ID_W    = 6;
   localparam int COORD_W = 16;
   localparam int SIZE_W  = 16;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ENTER = 2'd1,
      EV_STAY  = 2'd2,
      EV_EXIT  = 2'd3
   } contact_event_type;

   typedef struct packed {
      logic [ID_W-1:0]           left_id;
      logic [ID_W-1:0]           rhs_id;
      logic signed [COORD_W-1:0] left_x;
      logic signed [COORD_W-1:0] left_y;
      logic [SIZE_W-1:0]         left_w;
      logic [SIZE_W-1:0]         left_h;
      logic signed [COORD_W-1:0] right_x;
      logic signed [COORD_W-1:0] right_y;
      logic [SIZE_W-1:0]         right_w;
      logic [SIZE_W-1:0]         right_h;
      logic                      left_dead;
      logic                      right_dead;
   } aabb_pct_req_type;

   typedef struct packed {
      contact_event_type contact_event;
      logic              boxes_overlap;
   } aabb_pct_rsp_type;

endpackage

// File: rtl/aabb_pair_contact_tracker.sv
`timescale 1ns / 1ps

// Contact tracker for ordered collider pairs.
// req channel: one pair test per item (ids, box centers and sizes, dead flags).
// rsp channel: one item per request, in order: enter/stay/exit/none and the raw
// overlap flag. Both channels are valid/ready.
// Pipeline: the accepting edge loads the input stage and the contact-bit read;
// the result register loads and rsp_valid rises when the input stage advances.
// Throughput: one item per cycle unless stalled by rsp_ready. The contact bits
// live in a one-bit-wide RAM with a registered read; each item does one read and
// one write-back, and a write-back that hits the address read in the same cycle
// is forwarded, so back-to-back items on the same pair see each other's update.
// Reset: control state clears and a clearing pass writes zero to every contact
// bit, one address a cycle, 2^(2*ID_BITS) addresses (4096 at the default);
// req_ready stays low during that pass.
// Stall: with rsp_ready low the result register holds; one more item can sit
// in the input stage, after which req_ready drops until rsp_ready returns.
// Pairs with equal ids give no event and leave the contact bits untouched.

module aabb_pair_contact_tracker
   import aabb_pct_pkg::*;
#(
   parameter int ID_BITS = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  aabb_pct_req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aabb_pct_rsp_type rsp_data
);

   localparam int ADDR_BITS = 2 * ID_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;

   // strict overlap on one axis: 2*|rc-lc| < ls+rs, exact in fixed point
   function automatic logic axis_overlap(
      input logic [COORD_W-1:0] lc,
      input logic [SIZE_W-1:0]  ls,
      input logic [COORD_W-1:0] rc,
      input logic [SIZE_W-1:0]  rs
   );
      logic [COORD_W:0]   diff;
      logic [COORD_W-1:0] mag;
      logic [SIZE_W:0]    sum;
      diff = {rc[COORD_W-1], rc} - {lc[COORD_W-1], lc};
      mag  = diff[COORD_W] ? (~diff[COORD_W-1:0] + 1'b1) : diff[COORD_W-1:0];
      sum  = {1'b0, ls} + {1'b0, rs};
      return {mag, 1'b0} < sum;
   endfunction

   // ids reduced or extended to ID_BITS
   function automatic logic [ID_BITS-1:0] fit_id(input logic [ID_W-1:0] id);
      logic [ID_W+ID_BITS-1:0] wide;
      wide = {{ID_BITS{1'b0}}, id};
      return wide[ID_BITS-1:0];
   endfunction

   logic                 clr_active_ff, clr_active_in;
   logic [ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;

   logic             s1_valid_ff, s1_valid_in;
   aabb_pct_req_type s1_item_ff;
   logic             fwd_hit_ff, fwd_bit_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   aabb_pct_rsp_type rsp_data_ff, rsp_data_in;

   logic                 req_fire, s1_advance;
   logic [ADDR_BITS-1:0] req_addr, s1_addr;
   logic                 s1_same, s1_ov, s1_dead, s1_prev, s1_new_bit, s1_wr;
   contact_event_type    s1_event;

   logic                 ram_we, ram_wdata, ram_rdata;
   logic [ADDR_BITS-1:0] ram_waddr;

   // handshake
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !clr_active_ff && (!s1_valid_ff || s1_advance);
   assign req_fire   = req_valid && req_ready;

   assign req_addr = {fit_id(req_data.left_id), fit_id(req_data.rhs_id)};
   assign s1_addr  = {fit_id(s1_item_ff.left_id), fit_id(s1_item_ff.rhs_id)};

   // contact decision for the item in the input stage
   always_comb begin
      s1_same = s1_addr[ADDR_BITS-1:ID_BITS] == s1_addr[ID_BITS-1:0];
      s1_ov   = axis_overlap(s1_item_ff.left_x, s1_item_ff.left_w,
                             s1_item_ff.right_x, s1_item_ff.right_w) &&
                axis_overlap(s1_item_ff.left_y, s1_item_ff.left_h,
                             s1_item_ff.right_y, s1_item_ff.right_h);
      s1_dead    = s1_item_ff.left_dead || s1_item_ff.right_dead;
      s1_prev    = fwd_hit_ff ? fwd_bit_ff : ram_rdata;
      s1_new_bit = s1_ov && !s1_dead;
      s1_wr      = s1_advance && !s1_same;
      s1_event   = EV_NONE;
      if (!s1_same) begin
         if (s1_prev && !s1_new_bit) begin
            s1_event = EV_EXIT;
         end else if (s1_prev) begin
            s1_event = EV_STAY;
         end else if (s1_new_bit) begin
            s1_event = EV_ENTER;
         end
      end
   end

   // clearing pass owns the write port after reset
   always_comb begin
      ram_we    = clr_active_ff || s1_wr;
      ram_waddr = clr_active_ff ? clr_addr_ff : s1_addr;
      ram_wdata = clr_active_ff ? 1'b0 : s1_new_bit;
   end

   aabb_pct_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_contact_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      clr_active_in = clr_active_ff && (clr_addr_ff != {ADDR_BITS{1'b1}});
      clr_addr_in   = clr_active_ff ? clr_addr_ff + 1'b1 : clr_addr_ff;

      s1_valid_in = req_fire || (s1_valid_ff && !s1_advance);

      rsp_data_in.contact_event = s1_event;
      rsp_data_in.boxes_overlap = s1_ov;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and forwarding: the RAM read of a new item misses a write-back
   // to the same address in the same cycle, so that bit is kept aside
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_data;
         fwd_hit_ff <= s1_wr && (s1_addr == req_addr);
         fwd_bit_ff <= s1_new_bit;
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/aabb_pct_ram.sv
`timescale 1ns / 1ps

module aabb_pct_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/aabb_pct_checker.sv
`timescale 1ns / 1ps

module aabb_pct_props
   import aabb_pct_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input aabb_pct_req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input aabb_pct_rsp_type rsp_data
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // the clearing pass blocks requests right after reset
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // enter and stay only on an overlap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.contact_event == EV_ENTER ||
                    rsp_data.contact_event == EV_STAY) |-> rsp_data.boxes_overlap)
      else $error("enter or stay without overlap");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a request with equal ids never gives an event at the response port
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.left_id == req_data.rhs_id) &&
      rsp_ready |=> ##1 !rsp_valid || rsp_data.contact_event == EV_NONE ||
                         $past(rsp_valid, 1))
      else $error("event on a pair with equal ids");

endmodule

bind aabb_pair_contact_tracker aabb_pct_props u_aabb_pct_props (.*);
